// ===== rtl/spdpid_pkg.sv =====
// Shared types and constants for the segment speed controller.
// No dependencies.
package spdpid_pkg;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_CURVE_SPEED    = 3'd0;
   localparam csr_index_type CSR_STRAIGHT_SPEED = 3'd1;
   localparam csr_index_type CSR_PROP_GAIN      = 3'd2;
   localparam csr_index_type CSR_INTEG_GAIN     = 3'd3;
   localparam csr_index_type CSR_DERIV_GAIN     = 3'd4;

   localparam logic [7:0] CURVE_SPEED_RST    = 8'd48;
   localparam logic [7:0] STRAIGHT_SPEED_RST = 8'd63;
   localparam logic [7:0] PROP_GAIN_RST      = 8'd65;
   localparam logic [7:0] INTEG_GAIN_RST     = 8'd10;
   localparam logic [7:0] DERIV_GAIN_RST     = 8'd4;

   localparam logic [12:0] DUTY_MAX    = 13'd7000;
   localparam logic [12:0] BRAKE_START = 13'd4000;
   localparam logic [12:0] BRAKE_ENTRY = 13'd3200;
   localparam logic [12:0] BRAKE_RAMP  = 13'd2000;
   localparam logic [12:0] BRAKE_BASE  = 13'd1000;

   localparam logic signed [10:0] THR_ZERO = 11'sd0;
   localparam logic signed [10:0] THR_RAMP = 11'sd3;
   localparam logic signed [10:0] THR_BIG  = 11'sd10;
   localparam logic signed [10:0] THR_BASE = 11'sd6;

   localparam logic signed [10:0] DEFAULT_TARGET = 11'sd50;

   typedef struct packed {
      logic big_curve;
      logic curve_entry;
   } seg_flags_type;

   typedef struct packed {
      logic [8:0]  target_speed;
      logic        reverse;
      logic [12:0] brake_duty;
      logic        steer_gain_override;
   } seg_result_type;

endpackage

// ===== rtl/spdpid_classify.sv =====
// Segment classification and brake mode selection (combinational).
// Depends on spdpid_pkg.
module spdpid_classify (
   input  logic                       obstacle,
   input  logic [7:0]                 ramp_count,
   input  logic [7:0]                 straight_count,
   input  logic [7:0]                 global_curvature,
   input  logic signed [7:0]          lateral_offset,
   input  logic [7:0]                 curve_points,
   input  logic [7:0]                 near_curvature,
   input  logic [7:0]                 far_curvature,
   input  logic signed [9:0]          measured_speed,
   input  logic                       start_line,
   input  logic [7:0]                 setpoint,
   input  logic [7:0]                 curve_speed,
   input  logic [7:0]                 straight_speed,
   input  spdpid_pkg::seg_flags_type  flags_q,
   output spdpid_pkg::seg_flags_type  flags_next,
   output spdpid_pkg::seg_result_type result
);
   import spdpid_pkg::*;

   logic signed [10:0] cs_s;
   logic signed [10:0] meas_s;
   logic signed [10:0] setp_s;
   logic signed [10:0] over_speed;
   logic signed [10:0] tgt;
   logic signed [10:0] thr;
   logic               offset_small;
   logic               ramp_seen;
   logic               ramp_active;
   seg_flags_type      flags;

   assign cs_s         = $signed({3'b000, curve_speed});
   assign meas_s       = $signed({measured_speed[9], measured_speed});
   assign setp_s       = $signed({3'b000, setpoint});
   assign over_speed   = meas_s - setp_s;
   assign offset_small = (lateral_offset >= -8'sd18) && (lateral_offset <= 8'sd18);
   assign ramp_seen    = (ramp_count != 8'd0);
   assign ramp_active  = ramp_seen && (ramp_count < 8'd60);

   always_comb begin
      flags = flags_q;
      if (obstacle) begin
         tgt = cs_s - 11'sd4;
         flags.big_curve = 1'b0;
      end else if (ramp_active) begin
         tgt = cs_s;
         flags.big_curve = 1'b0;
      end else if (straight_count > 8'd30 && !ramp_seen) begin
         tgt = $signed({3'b000, straight_speed});
      end else if (straight_count > 8'd15 && straight_count < 8'd30 && !ramp_seen) begin
         tgt = cs_s + 11'sd5;
      end else if (global_curvature > 8'd10 && global_curvature <= 8'd25 && offset_small) begin
         tgt = cs_s;
         flags.big_curve = 1'b0;
      end else if (global_curvature > 8'd25 || !offset_small || curve_points > 8'd4) begin
         tgt = cs_s;
         flags.big_curve   = 1'b1;
         flags.curve_entry = 1'b0;
      end else begin
         tgt = DEFAULT_TARGET;
         flags.big_curve = 1'b0;
      end
      // straight running into a curve
      if (meas_s > cs_s + 11'sd4 && far_curvature > 8'd8 && near_curvature < 8'd5) begin
         tgt = cs_s - 11'sd3;
         flags.big_curve   = 1'b0;
         flags.curve_entry = 1'b1;
      end
   end

   always_comb begin
      result.steer_gain_override = 1'b0;
      if (start_line && meas_s > 11'sd3) begin
         result.brake_duty = BRAKE_START;
         thr = THR_ZERO;
         result.steer_gain_override = 1'b1;
      end else if (flags.curve_entry) begin
         result.brake_duty = BRAKE_ENTRY;
         thr = THR_ZERO;
      end else if (ramp_seen) begin
         result.brake_duty = BRAKE_RAMP;
         thr = THR_RAMP;
      end else if (flags.big_curve) begin
         result.brake_duty = BRAKE_BASE;
         thr = THR_BIG;
      end else begin
         result.brake_duty = BRAKE_BASE;
         thr = THR_BASE;
      end
      result.reverse      = (over_speed > thr);
      result.target_speed = tgt[10] ? 9'd0 : tgt[8:0];
   end

   assign flags_next = flags;

endmodule

// ===== rtl/spdpid_pid.sv =====
// Incremental PID: error history, registered gain products, duty sum and clamp.
// Depends on spdpid_pkg.
module spdpid_pid (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              commit,
   input  logic signed [9:0] measured_speed,
   input  logic [7:0]        setpoint,
   input  logic [7:0]        prop_gain,
   input  logic [7:0]        integ_gain,
   input  logic [7:0]        deriv_gain,
   output logic [12:0]       duty
);
   import spdpid_pkg::*;

   logic signed [10:0] err;
   logic signed [11:0] err_delta;
   logic signed [10:0] eh0_ff, eh1_ff, eh2_ff;
   logic signed [19:0] p_in, i_in, p_ff, i_ff;
   logic signed [20:0] d_in, d_ff;
   logic signed [22:0] acc;
   logic [12:0]        prev_duty_ff;

   assign err       = $signed({3'b000, setpoint}) - $signed({measured_speed[9], measured_speed});
   assign err_delta = $signed({err[10], err}) - $signed({eh2_ff[10], eh2_ff});
   assign p_in      = $signed({1'b0, prop_gain}) * err;
   assign i_in      = $signed({1'b0, integ_gain}) * eh0_ff;
   assign d_in      = $signed({1'b0, deriv_gain}) * err_delta;

   always_ff @(posedge clock) begin
      if (load) begin
         p_ff <= p_in;
         i_ff <= i_in;
         d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eh0_ff <= '0;
         eh1_ff <= '0;
         eh2_ff <= '0;
      end else if (load) begin
         eh0_ff <= err;
         eh1_ff <= eh0_ff;
         eh2_ff <= eh1_ff;
      end
   end

   assign acc = $signed({10'b0, prev_duty_ff})
              + $signed({{3{p_ff[19]}}, p_ff})
              - $signed({{3{i_ff[19]}}, i_ff})
              + $signed({{2{d_ff[20]}}, d_ff});

   always_comb begin
      if (acc[22]) begin
         duty = 13'd0;
      end else if (acc > $signed({10'b0, DUTY_MAX})) begin
         duty = DUTY_MAX;
      end else begin
         duty = acc[12:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_duty_ff <= '0;
      end else if (commit) begin
         prev_duty_ff <= duty;
      end
   end

endmodule

// ===== rtl/segment_speed_pid_with_brake.sv =====
// Top level of the segment-aware motor speed controller with brake.
// Depends on spdpid_pkg, spdpid_classify and spdpid_pid.
//
// Usage:
//   Request channel (req_*): one control tick of road features and speeds,
//   transferred when req_valid is high and req_stall is low.
//   Response channel (rsp_*): one result per tick (target speed, direction,
//   duty, steering override), transferred when rsp_valid is high and
//   rsp_stall is low. Results leave in request order.
//   Configuration (csr_*): csr_write with csr_index/csr_data writes one
//   register; write only while no tick is in flight.
// Pipeline: a tick passes the input register, the gain product register and
// the result register in that order; rsp_valid rises when the result
// register is loaded.
// Throughput: one tick per cycle while no response stall holds the pipeline;
// the previous-duty feedback closes through the combinational sum and clamp.
// Reset: synchronous; clears the pipeline, the segment flags, the error
// history and previous duty, and loads the register defaults.
// Stall: a stalled response holds; the pipeline keeps filling and req_stall
// rises only once all three stages hold a tick.
module segment_speed_pid_with_brake (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  spdpid_pkg::csr_index_type csr_index,
   input  logic [7:0]                csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_obstacle,
   input  logic [7:0]                req_ramp_count,
   input  logic [7:0]                req_straight_count,
   input  logic [7:0]                req_global_curvature,
   input  logic signed [7:0]         req_lateral_offset,
   input  logic [7:0]                req_curve_points,
   input  logic [7:0]                req_near_curvature,
   input  logic [7:0]                req_far_curvature,
   input  logic signed [9:0]         req_measured_speed,
   input  logic                      req_start_line,
   input  logic [7:0]                req_setpoint,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [8:0]                rsp_target_speed,
   output logic                      rsp_reverse,
   output logic [12:0]               rsp_duty,
   output logic                      rsp_steer_gain_override
);
   import spdpid_pkg::*;

   logic [7:0] curve_speed_ff, straight_speed_ff, prop_gain_ff, integ_gain_ff, deriv_gain_ff;

   logic               valid_a_ff, valid_a_in;
   logic               obstacle_ff;
   logic [7:0]         ramp_count_ff, straight_count_ff, global_curvature_ff;
   logic signed [7:0]  lateral_offset_ff;
   logic [7:0]         curve_points_ff, near_curvature_ff, far_curvature_ff;
   logic signed [9:0]  measured_speed_ff;
   logic               start_line_ff;
   logic [7:0]         setpoint_ff;

   logic               valid_b_ff, valid_b_in;
   seg_result_type     seg_b_ff;
   seg_result_type     seg_res;
   seg_flags_type      flags_ff, flags_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [8:0]         rsp_target_speed_ff;
   logic               rsp_reverse_ff;
   logic [12:0]        rsp_duty_ff;
   logic               rsp_override_ff;

   logic               out_free, move_b, b_free, move_a, a_free, take;
   logic [12:0]        pid_duty;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign move_b     = valid_b_ff && out_free;
   assign b_free     = !valid_b_ff || move_b;
   assign move_a     = valid_a_ff && b_free;
   assign a_free     = !valid_a_ff || move_a;
   assign req_stall  = !a_free;
   assign take       = req_valid && a_free;

   assign valid_a_in   = take || (valid_a_ff && !move_a);
   assign valid_b_in   = move_a || (valid_b_ff && !move_b);
   assign rsp_valid_in = move_b || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_speed_ff    <= CURVE_SPEED_RST;
         straight_speed_ff <= STRAIGHT_SPEED_RST;
         prop_gain_ff      <= PROP_GAIN_RST;
         integ_gain_ff     <= INTEG_GAIN_RST;
         deriv_gain_ff     <= DERIV_GAIN_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CURVE_SPEED:    curve_speed_ff    <= csr_data;
            CSR_STRAIGHT_SPEED: straight_speed_ff <= csr_data;
            CSR_PROP_GAIN:      prop_gain_ff      <= csr_data;
            CSR_INTEG_GAIN:     integ_gain_ff     <= csr_data;
            CSR_DERIV_GAIN:     deriv_gain_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         valid_a_ff   <= valid_a_in;
         valid_b_ff   <= valid_b_in;
         rsp_valid_ff <= rsp_valid_in;
         if (move_a) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         obstacle_ff         <= req_obstacle;
         ramp_count_ff       <= req_ramp_count;
         straight_count_ff   <= req_straight_count;
         global_curvature_ff <= req_global_curvature;
         lateral_offset_ff   <= req_lateral_offset;
         curve_points_ff     <= req_curve_points;
         near_curvature_ff   <= req_near_curvature;
         far_curvature_ff    <= req_far_curvature;
         measured_speed_ff   <= req_measured_speed;
         start_line_ff       <= req_start_line;
         setpoint_ff         <= req_setpoint;
      end
      if (move_a) begin
         seg_b_ff <= seg_res;
      end
      if (move_b) begin
         rsp_target_speed_ff <= seg_b_ff.target_speed;
         rsp_reverse_ff      <= seg_b_ff.reverse;
         rsp_duty_ff         <= seg_b_ff.reverse ? seg_b_ff.brake_duty : pid_duty;
         rsp_override_ff     <= seg_b_ff.steer_gain_override;
      end
   end

   spdpid_classify u_classify (
      .obstacle         (obstacle_ff),
      .ramp_count       (ramp_count_ff),
      .straight_count   (straight_count_ff),
      .global_curvature (global_curvature_ff),
      .lateral_offset   (lateral_offset_ff),
      .curve_points     (curve_points_ff),
      .near_curvature   (near_curvature_ff),
      .far_curvature    (far_curvature_ff),
      .measured_speed   (measured_speed_ff),
      .start_line       (start_line_ff),
      .setpoint         (setpoint_ff),
      .curve_speed      (curve_speed_ff),
      .straight_speed   (straight_speed_ff),
      .flags_q          (flags_ff),
      .flags_next       (flags_in),
      .result           (seg_res)
   );

   spdpid_pid u_pid (
      .clock          (clock),
      .reset          (reset),
      .load           (move_a),
      .commit         (move_b),
      .measured_speed (measured_speed_ff),
      .setpoint       (setpoint_ff),
      .prop_gain      (prop_gain_ff),
      .integ_gain     (integ_gain_ff),
      .deriv_gain     (deriv_gain_ff),
      .duty           (pid_duty)
   );

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_target_speed        = rsp_target_speed_ff;
   assign rsp_reverse             = rsp_reverse_ff;
   assign rsp_duty                = rsp_duty_ff;
   assign rsp_steer_gain_override = rsp_override_ff;

`ifndef SYNTH
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_a_ff && valid_b_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_fwd_duty_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_reverse_ff) |-> (rsp_duty_ff <= DUTY_MAX))
      else $error("forward duty above limit");

   a_brake_duty_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_reverse_ff) |-> (rsp_duty_ff == BRAKE_START ||
         rsp_duty_ff == BRAKE_ENTRY || rsp_duty_ff == BRAKE_RAMP ||
         rsp_duty_ff == BRAKE_BASE))
      else $error("brake duty not a brake level");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !valid_a_ff && !valid_b_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
